FILE: rtl/s256_pkg.sv
// Shared types and codes of the streaming SHA-256 hasher.
package s256_pkg;

   // Request mode codes.
   localparam logic [1:0] MODE_ABSORB        = 2'd0;
   localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] MODE_FINISH        = 2'd2;

   // Eight 32-bit hash words, index 0 is H0.
   typedef logic [7:0][31:0] s256_hash_type;

   // Commands from the sequencer to the compression datapath.
   typedef struct packed {
      logic       load_byte;
      logic [7:0] byte_val;
      logic       init_vars;
      logic       do_round;
      logic [5:0] round_idx;
      logic       fold;
      logic       restart;
   } s256_cmd_type;

endpackage

FILE: rtl/s256_req_if.sv
// Request channel: one message byte and a mode code per item.
interface s256_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

FILE: rtl/s256_rsp_if.sv
// Response channel: one 64-bit quarter of the digest per item.
interface s256_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part;
   logic [1:0]  part_index;
   logic        last_part;

   modport source (output valid, output digest_part, output part_index, output last_part,
                   input ready);
   modport sink (input valid, input digest_part, input part_index, input last_part,
                 output ready);
endinterface

FILE: rtl/s256_core.sv
// SHA-256 compression datapath: message window, working variables, hash words, one round unit.
module s256_core (
   input  logic                  clock,
   input  logic                  reset,
   input  s256_pkg::s256_cmd_type cmd,
   output s256_pkg::s256_hash_type hash
);
   import s256_pkg::*;

   localparam s256_hash_type S256_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [0:63][31:0] S256_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Message window: the oldest word sits in the top 32 bits, bytes enter at the bottom.
   logic [511:0]  win_ff, win_in;
   s256_hash_type var_ff, var_in;
   s256_hash_type hash_ff, hash_in;

   logic [31:0] w_old, w_m15, w_m7, w_m2, w_sum, w_cur;
   logic [31:0] s0_w, s1_w, big_s0, big_s1, ch_v, maj_v, t1_v, t2_v;
   logic [31:0] a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // Window taps relative to the current round.
   assign w_old = win_ff[511:480];
   assign w_m15 = win_ff[479:448];
   assign w_m7  = win_ff[223:192];
   assign w_m2  = win_ff[63:32];

   // Message schedule expansion.
   assign s0_w  = rotr(w_m15, 7) ^ rotr(w_m15, 18) ^ (w_m15 >> 3);
   assign s1_w  = rotr(w_m2, 17) ^ rotr(w_m2, 19) ^ (w_m2 >> 10);
   assign w_sum = w_old + s0_w + w_m7 + s1_w;
   assign w_cur = (cmd.round_idx[5:4] == 2'd0) ? w_old : w_sum;

   // Round function on the working variables.
   assign a_v = var_ff[0];
   assign b_v = var_ff[1];
   assign c_v = var_ff[2];
   assign d_v = var_ff[3];
   assign e_v = var_ff[4];
   assign f_v = var_ff[5];
   assign g_v = var_ff[6];
   assign h_v = var_ff[7];
   assign big_s1 = rotr(e_v, 6) ^ rotr(e_v, 11) ^ rotr(e_v, 25);
   assign big_s0 = rotr(a_v, 2) ^ rotr(a_v, 13) ^ rotr(a_v, 22);
   assign ch_v   = (e_v & f_v) ^ (~e_v & g_v);
   assign maj_v  = (a_v & b_v) ^ (a_v & c_v) ^ (b_v & c_v);
   assign t1_v   = h_v + big_s1 + ch_v + S256_K[cmd.round_idx] + w_cur;
   assign t2_v   = big_s0 + maj_v;

   // Next-state selection under the sequencer's command.
   always_comb begin
      win_in  = win_ff;
      var_in  = var_ff;
      hash_in = hash_ff;
      if (cmd.load_byte) begin
         win_in = {win_ff[503:0], cmd.byte_val};
      end
      if (cmd.init_vars) begin
         var_in = hash_ff;
      end
      if (cmd.do_round) begin
         win_in = {win_ff[479:0], w_cur};
         var_in = {g_v, f_v, e_v, d_v + t1_v, c_v, b_v, a_v, t1_v + t2_v};
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + var_ff[i];
         end
      end
      if (cmd.restart) begin
         hash_in = S256_IV;
      end
   end

   // Hash words start from the initial value.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= S256_IV;
      end else begin
         hash_ff <= hash_in;
      end
   end

   // Window and working variables are always written before they are read.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      var_ff <= var_in;
   end

   assign hash = hash_ff;

endmodule

FILE: rtl/sha256_stream_hasher_unit.sv
// Top level of the streaming SHA-256 hasher: sequencer, padding and digest output.
//
//   channel   dir   item                               handshake
//   req_port  in    mode, data_byte                    valid/ready
//   rsp_port  out   digest_part, part_index, last_part valid/ready
//
// A plain byte leaves the sequencer idle. The byte that completes a 64-byte block starts a
// compression: the working variables are loaded, 64 rounds run through the single round
// unit, and the result is added into the hash words. A finish pads one byte per cycle up to
// the block end, runs one or two compressions, then offers four digest items, one per cycle
// at best. Reset is synchronous and puts the initial hash value in place. After a finish or
// a block-ending byte, requests are refused from the next cycle until its work and output are done.
module sha256_stream_hasher_unit (
   input logic       clock,
   input logic       reset,
   s256_req_if.sink  req_port,
   s256_rsp_if.source rsp_port
);
   import s256_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   logic [5:0]    fill_ff, fill_in;
   logic [60:0]   msg_ff, msg_in;
   logic [63:0]   len_ff, len_in;
   logic          mark_ff, mark_in;
   logic          lenph_ff, lenph_in;
   logic [5:0]    round_ff, round_in;
   logic [1:0]    part_ff, part_in;

   s256_cmd_type  cmd;
   s256_hash_type hash;
   logic [60:0]   msg_next;
   logic          req_take, rsp_take, pad_len;

   s256_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .hash  (hash)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign rsp_port.valid = (state_ff == ST_OUT);
   assign rsp_take       = rsp_port.valid && rsp_port.ready;
   assign msg_next       = msg_ff + 61'd1;

   // Length bytes follow once the marker is in and the block has reached byte 56.
   assign pad_len = mark_ff && (lenph_ff || (fill_ff == 6'd56));

   // Digest output straight from the hash words, two words per item.
   assign rsp_port.digest_part = {hash[{part_ff, 1'b0}], hash[{part_ff, 1'b1}]};
   assign rsp_port.part_index  = part_ff;
   assign rsp_port.last_part   = (part_ff == 2'd3);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      fill_in  = fill_ff;
      msg_in   = msg_ff;
      len_in   = len_ff;
      mark_in  = mark_ff;
      lenph_in = lenph_ff;
      round_in = round_ff;
      part_in  = part_ff;
      cmd      = '0;
      cmd.round_idx = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_port.mode)
                  MODE_ABSORB: begin
                     cmd.load_byte = 1'b1;
                     cmd.byte_val  = req_port.data_byte;
                     fill_in       = fill_ff + 6'd1;
                     msg_in        = msg_next;
                     if (fill_ff == 6'd63) begin
                        state_in = ST_LOAD;
                        ret_in   = ST_IDLE;
                     end
                  end
                  MODE_ABSORB_FINISH: begin
                     cmd.load_byte = 1'b1;
                     cmd.byte_val  = req_port.data_byte;
                     fill_in       = fill_ff + 6'd1;
                     msg_in        = '0;
                     len_in        = {msg_next, 3'b000};
                     mark_in       = 1'b0;
                     lenph_in      = 1'b0;
                     part_in       = '0;
                     if (fill_ff == 6'd63) begin
                        state_in = ST_LOAD;
                        ret_in   = ST_PAD;
                     end else begin
                        state_in = ST_PAD;
                     end
                  end
                  MODE_FINISH: begin
                     msg_in   = '0;
                     len_in   = {msg_ff, 3'b000};
                     mark_in  = 1'b0;
                     lenph_in = 1'b0;
                     part_in  = '0;
                     state_in = ST_PAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            cmd.init_vars = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_PAD: begin
            // Marker byte, then zeros, then the bit length most significant byte first.
            cmd.load_byte = 1'b1;
            if (!mark_ff) begin
               cmd.byte_val = 8'h80;
            end else if (pad_len) begin
               cmd.byte_val = len_ff[63:56];
            end else begin
               cmd.byte_val = 8'h00;
            end
            fill_in = fill_ff + 6'd1;
            mark_in = 1'b1;
            if (pad_len) begin
               lenph_in = 1'b1;
               len_in   = {len_ff[55:0], 8'h00};
            end
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
               ret_in   = pad_len ? ST_OUT : ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         msg_ff   <= '0;
         mark_ff  <= 1'b0;
         lenph_ff <= 1'b0;
         round_ff <= '0;
         part_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         msg_ff   <= msg_in;
         mark_ff  <= mark_in;
         lenph_ff <= lenph_in;
         round_ff <= round_in;
         part_ff  <= part_in;
      end
   end

   // Latched bit length of the message being finished.
   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench of the streaming SHA-256 hasher with its own digest predictor.
module tb_top;
   import s256_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Mode code that the block must ignore.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [0:7][31:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // One expected digest quarter.
   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } digest_quarter_type;

   logic clock;
   logic reset;

   s256_req_if req_port ();
   s256_rsp_if rsp_port ();

   sha256_stream_hasher_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

   // Predicted hasher state.
   logic [31:0]        pred_hash [8];
   logic [7:0]         pred_block [64];
   int unsigned        pred_fill;
   logic [60:0]        pred_length;
   digest_quarter_type pending_digests [$];

   int  error_count;
   bit  idle_enable;
   bit  hold_request;
   int  hold_cycles;
   int  finishes_sent;

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_prediction();
      for (int j = 0; j < 8; j++) pred_hash[j] = INIT_HASH[j];
      pred_fill   = 0;
      pred_length = '0;
   endtask

   // Sixty-four rounds over the predicted block store, folded into the hash words.
   task automatic compress_predicted_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, s0, s1, t1, t2, w15, w2;
      for (int j = 0; j < 16; j++) begin
         w[j] = {pred_block[4 * j], pred_block[4 * j + 1], pred_block[4 * j + 2],
                 pred_block[4 * j + 3]};
      end
      for (int j = 0; j < 8; j++) v[j] = pred_hash[j];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            w15 = w[(t - 15) & 15];
            w2  = w[(t - 2) & 15];
            s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
            s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
            wt  = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
            w[t & 15] = wt;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) pred_hash[j] = pred_hash[j] + v[j];
   endtask

   task automatic absorb_predicted_byte(input logic [7:0] data_byte);
      pred_block[pred_fill] = data_byte;
      pred_fill++;
      pred_length = pred_length + 61'd1;
      if (pred_fill == 64) begin
         compress_predicted_block();
         pred_fill = 0;
      end
   endtask

   // Padding, last one or two compressions and the four expected digest quarters.
   task automatic finish_predicted_message();
      logic [63:0]        len_bits;
      int unsigned        i;
      digest_quarter_type quarter;
      len_bits = {pred_length, 3'b000};
      pred_block[pred_fill] = 8'h80;
      i = pred_fill + 1;
      if (i > 56) begin
         while (i < 64) begin
            pred_block[i] = 8'h00;
            i++;
         end
         compress_predicted_block();
         i = 0;
      end
      while (i < 56) begin
         pred_block[i] = 8'h00;
         i++;
      end
      for (int k = 0; k < 8; k++) pred_block[56 + k] = len_bits[63 - 8 * k -: 8];
      compress_predicted_block();
      for (int k = 0; k < 4; k++) begin
         quarter.digest_part = {pred_hash[2 * k], pred_hash[2 * k + 1]};
         quarter.part_index  = k[1:0];
         quarter.last_part   = (k == 3);
         pending_digests.push_back(quarter);
      end
      restart_prediction();
   endtask

   // Every accepted request item updates the prediction.
   always @(posedge clock) begin
      if (!reset && req_port.valid && req_port.ready) begin
         case (req_port.mode)
            MODE_ABSORB: begin
               absorb_predicted_byte(req_port.data_byte);
            end
            MODE_ABSORB_FINISH: begin
               absorb_predicted_byte(req_port.data_byte);
               finish_predicted_message();
            end
            MODE_FINISH: begin
               finish_predicted_message();
            end
            default: begin
            end
         endcase
      end
   end

   // Every accepted digest item is compared with the oldest expectation.
   always @(posedge clock) begin
      digest_quarter_type want;
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (pending_digests.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: unexpected digest item %h index %0d last %0b", $realtime,
                        rsp_port.digest_part, rsp_port.part_index, rsp_port.last_part);
            end
         end else begin
            want = pending_digests.pop_front();
            if (rsp_port.digest_part !== want.digest_part ||
                rsp_port.part_index !== want.part_index ||
                rsp_port.last_part !== want.last_part) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                           $realtime, want.digest_part, want.part_index, want.last_part,
                           rsp_port.digest_part, rsp_port.part_index, rsp_port.last_part);
               end
            end
         end
      end
   end

   // Result receiver: random stall bursts, plus a long hold-off when one is requested.
   initial begin
      int stall_left;
      stall_left  = 0;
      hold_cycles = 0;
      rsp_port.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && hold_cycles == 0) begin
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            rsp_port.ready <= 1'b0;
            hold_cycles--;
            if (hold_cycles == 0) hold_request = 1'b0;
         end else if (idle_enable && stall_left > 0) begin
            rsp_port.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_port.ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
         end
      end
   end

   // Offers one request item and returns at the falling edge after it is accepted.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] data_byte);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_port.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_port.valid     <= 1'b1;
      req_port.mode      <= mode;
      req_port.data_byte <= data_byte;
      do @(posedge clock); while (!(req_port.valid && req_port.ready));
      @(negedge clock);
      if (mode != MODE_ABSORB && mode != MODE_UNUSED) finishes_sent++;
   endtask

   // A message of random bytes, closed by an absorb-and-finish item or a bare finish.
   task automatic send_message(input int length, input bit finish_with_byte);
      for (int n = 0; n < length; n++) begin
         if (finish_with_byte && n == length - 1) begin
            send_item(MODE_ABSORB_FINISH, 8'($urandom));
         end else begin
            send_item(MODE_ABSORB, 8'($urandom));
         end
      end
      if (!finish_with_byte || length == 0) send_item(MODE_FINISH, 8'($urandom));
   endtask

   task automatic wait_for_drain();
      req_port.valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Extremes of the byte, every mode, the empty message and the ignored mode.
   task automatic test_directed_cases();
      send_item(MODE_FINISH, 8'h00);
      send_item(MODE_UNUSED, 8'hff);
      send_item(MODE_ABSORB_FINISH, 8'h00);
      send_item(MODE_ABSORB_FINISH, 8'hff);
      send_item(MODE_ABSORB, 8'h00);
      send_item(MODE_UNUSED, 8'h5a);
      send_item(MODE_ABSORB, 8'hff);
      send_item(MODE_ABSORB, 8'ha5);
      send_item(MODE_ABSORB_FINISH, 8'h5a);
      send_item(MODE_UNUSED, 8'h00);
      send_item(MODE_FINISH, 8'hff);
      send_item(MODE_FINISH, 8'h3c);
      send_item(MODE_ABSORB, 8'h61);
      send_item(MODE_ABSORB, 8'h62);
      send_item(MODE_ABSORB, 8'h63);
      send_item(MODE_FINISH, 8'h00);
   endtask

   // Lengths where the padding just fits, and a message of exactly one block.
   task automatic test_block_boundaries();
      send_message(55, 1'b1);
      send_message(64, 1'b0);
   endtask

   // The receiver holds off while several short messages are offered.
   task automatic test_output_backpressure();
      hold_request = 1'b1;
      for (int m = 0; m < 4; m++) begin
         send_message($urandom_range(0, 5), 1'($urandom_range(0, 1)));
      end
   endtask

   // A message whose padding needs a second block, then a full pause, a short message and another pause.
   task automatic test_drain_pause();
      send_message(56, 1'b1);
      wait_for_drain();
      send_message(3, 1'b1);
      wait_for_drain();
   endtask

   // Mostly well-formed random messages, with ignored items and bare finishes as noise.
   task automatic test_random_messages();
      int counted;
      int length;
      int start_finishes;
      counted        = 0;
      start_finishes = finishes_sent;
      while (counted < 20 || finishes_sent - start_finishes < 4) begin
         idle_enable = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 19))
            0, 1: begin
               send_item(MODE_UNUSED, 8'($urandom));
            end
            2: begin
               send_item(MODE_FINISH, 8'($urandom));
               counted++;
            end
            default: begin
               length = $urandom_range(0, 12);
               for (int n = 0; n < length; n++) begin
                  if ($urandom_range(0, 19) == 0) send_item(MODE_UNUSED, 8'($urandom));
                  send_item(MODE_ABSORB, 8'($urandom));
               end
               send_item($urandom_range(0, 1) ? MODE_ABSORB_FINISH : MODE_FINISH,
                         8'($urandom));
               counted += length + 1;
            end
         endcase
      end
   endtask

   // Closing stretch with both sides always ready.
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      for (int m = 0; m < 3; m++) begin
         send_message($urandom_range(0, 6), 1'($urandom_range(0, 1)));
      end
   endtask

   // Main sequence.
   initial begin
      error_count        = 0;
      finishes_sent      = 0;
      idle_enable        = 1'b1;
      hold_request       = 1'b0;
      reset              = 1'b1;
      req_port.valid     = 1'b0;
      req_port.mode      = MODE_ABSORB;
      req_port.data_byte = 8'h00;
      restart_prediction();
      for (int j = 0; j < 64; j++) pred_block[j] = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_block_boundaries();
      test_output_backpressure();
      test_drain_pause();
      test_random_messages();
      test_back_to_back();

      // Let the last results and any trailing compression settle.
      req_port.valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
